// File: rtl/accumulator_machine_executor_defines.svh
// Assertion helpers used by the executor RTL.
`ifndef ACCUMULATOR_MACHINE_EXECUTOR_DEFINES_SVH
`define ACCUMULATOR_MACHINE_EXECUTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AMX_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AMX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/amx_pkg.sv
`default_nettype none

package amx_pkg;

    localparam int MEM_DEPTH_DEF  = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    // Field widths
    localparam int OPCODE_W     = 4;
    localparam int ADDR_FIELD_W = 10;
    localparam int OPERAND_W    = 32;
    localparam int SHOWN_W      = 32;
    localparam int STATUS_W     = 2;
    localparam int IN_TDATA_W   = 56;
    localparam int OUT_TDATA_W  = 40;
    localparam int OUT_TUSER_W  = 3;

    // Address reduction: source width
    localparam int RED_SRC_W = 32;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SET   = 4'd0,
        OP_LDR   = 4'd1,
        OP_ADD   = 4'd2,
        OP_INC   = 4'd3,
        OP_DEC   = 4'd4,
        OP_STR   = 4'd5,
        OP_SHW   = 4'd6,
        OP_PAUSE = 4'd7,
        OP_END   = 4'd8
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_UNKNOWN = 2'd1,
        STAT_HALTED  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_EXEC
    } t_state;

    // SHW selectors (first_addr)
    localparam logic [ADDR_FIELD_W-1:0] SEL_WORD = 10'd0;
    localparam logic [ADDR_FIELD_W-1:0] SEL_ACC  = 10'd1;
    localparam logic [ADDR_FIELD_W-1:0] SEL_MAR  = 10'd2;
    localparam logic [ADDR_FIELD_W-1:0] SEL_CTRL = 10'd4;

endpackage

`default_nettype wire

// File: rtl/amx_addr_red.sv
`default_nettype none

module amx_addr_red #(
    parameter int MEM_DEPTH = amx_pkg::MEM_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [amx_pkg::RED_SRC_W-1:0]  i_value,
    output logic [$clog2(MEM_DEPTH)-1:0]        o_addr,
    output logic                                o_done
);

    localparam int AW      = $clog2(MEM_DEPTH);
    localparam bit IS_POW2 = ((1 << AW) == MEM_DEPTH);
    localparam int SW      = amx_pkg::RED_SRC_W;

    generate
        if (IS_POW2) begin : g_pow2
            // modulo is a plain slice
            assign o_addr = i_value[AW-1:0];
            assign o_done = i_start;
        end else begin : g_recip
            // x mod D = x - q*D with q from a reciprocal multiply; q comes out
            // low by at most one, fixed by a final compare and subtract
            localparam int          SH    = SW - 1 + AW;
            localparam int          QW    = SW + 1 - AW;
            localparam logic [SW-1:0] RECIP =
                SW'(((2*SW)'(1) << SH) / (2*SW)'(MEM_DEPTH));
            localparam logic [AW:0] MOD   = (AW+1)'(MEM_DEPTH);

            logic [SW-1:0]     r_val;
            logic [QW-1:0]     r_q;
            logic [AW:0]       r_rem;
            logic [2:0]        r_stg;
            logic [2*SW-1:0]   prod;
            logic [SW:0]       rem_full;

            assign prod     = (2*SW)'(r_val) * (2*SW)'(RECIP);
            assign rem_full = (SW+1)'(r_val) - (SW+1)'(r_q) * (SW+1)'(MEM_DEPTH);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_stg <= '0;
                end else begin
                    r_stg <= {r_stg[1:0], i_start};
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_val <= i_value;
                end
                r_q   <= prod[2*SW-1:SH];
                r_rem <= rem_full[AW:0];
            end

            assign o_addr = (r_rem >= MOD) ? AW'(r_rem - MOD) : r_rem[AW-1:0];
            assign o_done = r_stg[2];
        end
    endgenerate

endmodule

`default_nettype wire

// File: rtl/accumulator_machine_executor.sv
// Sequence: power-of-two MEM_DEPTH: each instruction is accepted (operands read), then executed;
//   result sits in the output register from the cycle after execute.
// Other MEM_DEPTH: addresses first go through the pipelined modulo unit (r_val, r_q, r_rem).
// The next instruction waits for the last to execute; execute can stall on m_axis_tready.
// Reset: synchronous active low; a sweep over all MEM_DEPTH words zeroes the data memory,
//   s_axis_tready stays low until it ends. Accumulator and halt flag clear at once.
`default_nettype none
`include "accumulator_machine_executor_defines.svh"

module accumulator_machine_executor #(
    parameter int MEM_DEPTH  = amx_pkg::MEM_DEPTH_DEF,
    parameter int DATA_WIDTH = amx_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [9:0] first_addr, [41:10] second_operand, [51:42] third_addr, [55:52] zero
    input  wire logic [amx_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [3:0] opcode
    input  wire logic [amx_pkg::OPCODE_W-1:0]     s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [31:0] shown_value, [32] halted, [39:33] zero
    output logic [amx_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // [0] shown_valid, [2:1] status
    output logic [amx_pkg::OUT_TUSER_W-1:0]       m_axis_tuser
);

    localparam int AW = $clog2(MEM_DEPTH);
    localparam int DW = DATA_WIDTH;
    localparam int FW = amx_pkg::ADDR_FIELD_W;

    // input fields
    logic [FW-1:0]                   in_first_addr;
    logic [amx_pkg::OPERAND_W-1:0]   in_operand;
    logic [FW-1:0]                   in_third_addr;
    logic                            in_fire;

    assign in_first_addr = s_axis_tdata[FW-1:0];
    assign in_operand    = s_axis_tdata[FW+amx_pkg::OPERAND_W-1:FW];
    assign in_third_addr = s_axis_tdata[2*FW+amx_pkg::OPERAND_W-1:FW+amx_pkg::OPERAND_W];

    amx_pkg::t_state r_state, n_state;

    logic [amx_pkg::OPCODE_W-1:0]    r_op;
    logic [FW-1:0]                   r_a1raw;
    logic [amx_pkg::OPERAND_W-1:0]   r_op2;
    logic                            r_a3_zero;
    logic [AW-1:0]                   r_a1;
    logic [AW-1:0]                   r_a3;
    logic [AW-1:0]                   r_clr_addr;
    logic [DW-1:0]                   r_acc, n_acc;
    logic                            r_halt, n_halt;

    // data memory, two read ports, one write port
    logic [DW-1:0]                   r_mem [MEM_DEPTH];
    logic [DW-1:0]                   r_rd0;
    logic [DW-1:0]                   r_rd1;
    logic                            mem_we;
    logic [AW-1:0]                   mem_waddr;
    logic [DW-1:0]                   mem_wdata;
    logic                            rd_en;

    // address reduction
    logic [AW-1:0]                   red_a1, red_a2, red_a3;
    logic                            red_done1, red_done2, red_done3;
    logic                            red_done;

    // output register
    logic                            r_out_valid;
    logic [amx_pkg::SHOWN_W-1:0]     r_out_shown;
    logic                            r_out_svalid;
    logic                            r_out_halted;
    amx_pkg::t_status                r_out_status;

    logic                            exec_fire;
    logic [DW-1:0]                   res_shown;
    logic                            res_svalid;
    amx_pkg::t_status                res_status;
    logic [DW-1:0]                   sum_ab;

    assign s_axis_tready = (r_state == amx_pkg::S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign exec_fire     = (r_state == amx_pkg::S_EXEC) && (!r_out_valid || m_axis_tready);
    assign red_done      = red_done1 && red_done2 && red_done3;
    assign rd_en         = red_done && (in_fire || (r_state == amx_pkg::S_REDUCE));
    assign sum_ab        = r_rd0 + r_rd1;

    amx_addr_red #(.MEM_DEPTH(MEM_DEPTH)) u_red_a1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_fire),
        .i_value (amx_pkg::RED_SRC_W'(in_first_addr)),
        .o_addr  (red_a1),
        .o_done  (red_done1)
    );

    amx_addr_red #(.MEM_DEPTH(MEM_DEPTH)) u_red_a2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_fire),
        .i_value (in_operand),
        .o_addr  (red_a2),
        .o_done  (red_done2)
    );

    amx_addr_red #(.MEM_DEPTH(MEM_DEPTH)) u_red_a3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_fire),
        .i_value (amx_pkg::RED_SRC_W'(in_third_addr)),
        .o_addr  (red_a3),
        .o_done  (red_done3)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd0 <= r_mem[red_a1];
            r_rd1 <= r_mem[red_a2];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_acc      = r_acc;
        n_halt     = r_halt;
        mem_we     = 1'b0;
        mem_waddr  = r_a1;
        mem_wdata  = '0;
        res_shown  = '0;
        res_svalid = 1'b0;
        res_status = amx_pkg::STAT_OK;

        case (r_state)
            amx_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                if (r_clr_addr == AW'(MEM_DEPTH-1)) begin
                    n_state = amx_pkg::S_IDLE;
                end
            end
            amx_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_state = red_done ? amx_pkg::S_EXEC : amx_pkg::S_REDUCE;
                end
            end
            amx_pkg::S_REDUCE: begin
                if (red_done) begin
                    n_state = amx_pkg::S_EXEC;
                end
            end
            amx_pkg::S_EXEC: begin
                if (exec_fire) begin
                    n_state = amx_pkg::S_IDLE;
                    if (r_halt) begin
                        res_status = amx_pkg::STAT_HALTED;
                    end else begin
                        case (r_op)
                            amx_pkg::OP_SET: begin
                                mem_we    = 1'b1;
                                mem_wdata = DW'($signed(r_op2));
                            end
                            amx_pkg::OP_LDR: begin
                                n_acc = r_rd0;
                            end
                            amx_pkg::OP_ADD: begin
                                if ((r_op2 == '0) && r_a3_zero) begin
                                    n_acc = r_acc + r_rd0;
                                end else if (r_a3_zero) begin
                                    n_acc = sum_ab;
                                end else begin
                                    mem_we    = 1'b1;
                                    mem_waddr = r_a3;
                                    mem_wdata = sum_ab;
                                end
                            end
                            amx_pkg::OP_INC: begin
                                mem_we    = 1'b1;
                                mem_wdata = r_rd0 + DW'(1);
                            end
                            amx_pkg::OP_DEC: begin
                                mem_we    = 1'b1;
                                mem_wdata = r_rd0 - DW'(1);
                            end
                            amx_pkg::OP_STR: begin
                                mem_we    = 1'b1;
                                mem_wdata = r_acc;
                            end
                            amx_pkg::OP_SHW: begin
                                if (r_a1raw == amx_pkg::SEL_WORD) begin
                                    res_shown  = r_rd1;
                                    res_svalid = 1'b1;
                                end else if (r_a1raw == amx_pkg::SEL_ACC) begin
                                    res_shown  = r_acc;
                                    res_svalid = 1'b1;
                                end else if ((r_a1raw >= amx_pkg::SEL_MAR) &&
                                             (r_a1raw <= amx_pkg::SEL_CTRL)) begin
                                    // MAR, MDR and control never get written
                                    res_svalid = 1'b1;
                                end
                            end
                            amx_pkg::OP_PAUSE: begin
                                res_shown  = r_acc;
                                res_svalid = 1'b1;
                                n_halt     = 1'b1;
                            end
                            amx_pkg::OP_END: begin
                                res_shown  = r_acc;
                                res_svalid = 1'b1;
                            end
                            default: begin
                                res_status = amx_pkg::STAT_UNKNOWN;
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_state = amx_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= amx_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_acc       <= '0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_halt  <= n_halt;
            if (r_state == amx_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op      <= s_axis_tuser;
            r_a1raw   <= in_first_addr;
            r_op2     <= in_operand;
            r_a3_zero <= (in_third_addr == '0);
        end
        if (rd_en) begin
            r_a1 <= red_a1;
            r_a3 <= red_a3;
        end
        if (exec_fire) begin
            r_out_shown  <= amx_pkg::SHOWN_W'(res_shown);
            r_out_svalid <= res_svalid;
            r_out_halted <= n_halt;
            r_out_status <= res_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(amx_pkg::OUT_TDATA_W-amx_pkg::SHOWN_W-1){1'b0}},
                            r_out_halted, r_out_shown};
    assign m_axis_tuser  = {r_out_status, r_out_svalid};

    `AMX_ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, r_halt, r_halt,
                     "halt flag cleared without reset")
    `AMX_ASSERT_NEXT(a_halt_status, i_clk, i_rst_n, exec_fire && r_halt,
                     (m_axis_tuser[2:1] == amx_pkg::STAT_HALTED) && m_axis_tdata[32],
                     "item executed while halted")
    `AMX_ASSERT_IMPLY(a_no_wr_on_accept, i_clk, i_rst_n, s_axis_tready, !mem_we,
                      "memory written while idle")
    `AMX_ASSERT_IMPLY(a_red_timing, i_clk, i_rst_n, red_done,
                      (r_state == amx_pkg::S_IDLE) || (r_state == amx_pkg::S_REDUCE),
                      "address reduction finished out of sequence")

endmodule

`default_nettype wire
